// ===== src/fsdd_pkg.sv =====
// ============================================================================
// fsdd_pkg: shared types and constants of the frame sequence drop detector
// ----------------------------------------------------------------------------
// This package holds the field widths, the pattern and histogram sizes, the
// register indexes, and the packed request and response payload types.
// ============================================================================
`default_nettype none

package fsdd_pkg;

   // Field widths that the interface fixes.
   localparam int unsigned TYPE_WIDTH        = 2;
   localparam int unsigned TIME_WIDTH        = 32;
   localparam int unsigned LEVEL_WIDTH       = 8;
   localparam int unsigned COUNT_WIDTH       = 32;
   localparam int unsigned FRAME_WIDTH_WIDTH = 20;

   // Length of the repeating test pattern (2 to 4).
   localparam int unsigned PATTERN_LENGTH = 4;

   // Number of level histogram bins (2 to 256) and the bin index width.
   localparam int unsigned LEVEL_BINS      = 16;
   localparam int unsigned BIN_INDEX_WIDTH = $clog2(LEVEL_BINS);

   // Drop threshold is the missing count times the frame width.
   localparam int unsigned THRESHOLD_WIDTH = TYPE_WIDTH + FRAME_WIDTH_WIDTH;

   // Configuration port.
   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH  = FRAME_WIDTH_WIDTH;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NORMAL_LEVEL   = 4'd0,
      CSR_FRAME_WIDTH_US = 4'd1
   } csr_index_type;

   localparam logic [LEVEL_WIDTH-1:0]       NORMAL_LEVEL_RESET   = 8'd1;
   localparam logic [FRAME_WIDTH_WIDTH-1:0] FRAME_WIDTH_US_RESET = 20'd16667;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [TYPE_WIDTH-1:0]  frame_type;
      logic [TIME_WIDTH-1:0]  start_time;
      logic [LEVEL_WIDTH-1:0] level;
   } req_payload_type;

   typedef struct packed {
      logic                  mismatch;
      logic [TYPE_WIDTH-1:0] missing_frames;
      logic                  judged_bad;
      count_type             total_count;
      count_type             normal_count;
      count_type             drop_count;
      count_type             bad_count;
      count_type             bin_count;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== src/frame_sequence_drop_detector.sv =====
// ============================================================================
// frame_sequence_drop_detector: pattern sequence checker for detected frames
// ----------------------------------------------------------------------------
// Checks that frame types advance through the test pattern, classifies each
// mismatch as dropped frames or a bad frame from the start time gap, and
// keeps saturating frame counters and a level histogram.
// ============================================================================
//
//   Channel  Direction  Handshake              Carries
//   req      in         req_valid / req_ready  frame type, start time, level
//   rsp      out        rsp_valid / rsp_ready  flags, counters, bin count
//   csr      in         csr_valid / csr_ready  register index, write data
//
// One frame per cycle is sustained while rsp_ready stays high. A frame is
// taken into an input register, checked by one stage of logic against the
// sequence state, and the result is written to an output register that
// drives rsp_valid and rsp_payload. The throughput is set by that single
// check stage and the histogram's one update per cycle. Reset clears the
// valid flags, sequence state, counters and histogram at once, and loads the
// register defaults. A stalled response holds the result; the input register
// still takes one more frame, after which req_ready follows rsp_ready.
//
`default_nettype none

module frame_sequence_drop_detector (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output      logic                                   req_ready,
   input  wire fsdd_pkg::req_payload_type              req_payload,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   output      fsdd_pkg::rsp_payload_type              rsp_payload,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [fsdd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [fsdd_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int unsigned TW = fsdd_pkg::TYPE_WIDTH;
   localparam int unsigned CW = fsdd_pkg::COUNT_WIDTH;

   // Input stage.
   logic                                      in_valid_ff;
   fsdd_pkg::req_payload_type                 in_data_ff;
   logic                                      advance;

   // Configuration registers.
   logic [fsdd_pkg::LEVEL_WIDTH-1:0]          normal_level_ff;
   logic [fsdd_pkg::FRAME_WIDTH_WIDTH-1:0]    frame_width_ff;

   // Sequence state and counters.
   logic [TW-1:0]                             expected_ff, expected_in;
   logic                                      seen_first_ff;
   logic [fsdd_pkg::TIME_WIDTH-1:0]           prev_start_ff;
   fsdd_pkg::count_type                       total_ff, total_in;
   fsdd_pkg::count_type                       normal_ff, normal_in;
   fsdd_pkg::count_type                       drop_ff, drop_in;
   fsdd_pkg::count_type                       bad_ff, bad_in;

   // Output stage.
   logic                                      rsp_valid_ff;
   fsdd_pkg::rsp_payload_type                 rsp_data_ff, rsp_data_in;

   // Check logic.
   logic [TW-1:0]                             ftype;
   logic [TW-1:0]                             exp_type;
   logic                                      match;
   logic [TW:0]                               wrap_diff;
   logic [TW-1:0]                             missing;
   logic [fsdd_pkg::THRESHOLD_WIDTH-1:0]      threshold;
   logic [fsdd_pkg::TIME_WIDTH-1:0]           gap;
   logic                                      dropped;
   logic                                      bad;
   logic [CW:0]                               total_sum, normal_sum, drop_sum, bad_sum;
   fsdd_pkg::count_type                       bin_count;

   // Handshakes: the check stage moves when the output register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_level_ff <= fsdd_pkg::NORMAL_LEVEL_RESET;
         frame_width_ff  <= fsdd_pkg::FRAME_WIDTH_US_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fsdd_pkg::CSR_NORMAL_LEVEL: begin
               normal_level_ff <= fsdd_pkg::LEVEL_WIDTH'(csr_wdata);
            end
            fsdd_pkg::CSR_FRAME_WIDTH_US: begin
               frame_width_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Type within the pattern and the expectation in force for this frame.
   always_comb begin
      ftype = (in_data_ff.frame_type >= TW'(fsdd_pkg::PATTERN_LENGTH % (1 << TW)) &&
               fsdd_pkg::PATTERN_LENGTH < (1 << TW))
              ? TW'(in_data_ff.frame_type - TW'(fsdd_pkg::PATTERN_LENGTH % (1 << TW)))
              : in_data_ff.frame_type;
      exp_type = seen_first_ff ? expected_ff : ftype;
      match    = (ftype == exp_type);
   end

   // Missing count, drop threshold and the start time gap.
   always_comb begin
      if (ftype >= exp_type) begin
         wrap_diff = {1'b0, ftype} - {1'b0, exp_type};
      end else begin
         wrap_diff = {1'b0, ftype} + (TW + 1)'(fsdd_pkg::PATTERN_LENGTH) - {1'b0, exp_type};
      end
      missing   = match ? '0 : wrap_diff[TW-1:0];
      threshold = fsdd_pkg::THRESHOLD_WIDTH'(missing) *
                  fsdd_pkg::THRESHOLD_WIDTH'(frame_width_ff);
      gap       = (in_data_ff.start_time >= prev_start_ff)
                  ? in_data_ff.start_time - prev_start_ff
                  : prev_start_ff - in_data_ff.start_time;
      dropped   = !match && (gap >= fsdd_pkg::TIME_WIDTH'(threshold));
      bad       = !match && !dropped;
   end

   // Next expectation: advance from the expected type or restart from this one.
   always_comb begin
      if (ftype == TW'(fsdd_pkg::PATTERN_LENGTH - 1)) begin
         expected_in = '0;
      end else begin
         expected_in = ftype + TW'(1);
      end
   end

   // Saturating counter updates.
   always_comb begin
      total_sum  = {1'b0, total_ff} + (CW + 1)'(1);
      normal_sum = {1'b0, normal_ff} + (CW + 1)'(1);
      drop_sum   = {1'b0, drop_ff} + (CW + 1)'(missing);
      bad_sum    = {1'b0, bad_ff} + (CW + 1)'(1);
      total_in   = total_sum[CW] ? '1 : total_sum[CW-1:0];
      normal_in  = normal_ff;
      drop_in    = drop_ff;
      bad_in     = bad_ff;
      if (match && (in_data_ff.level == normal_level_ff)) begin
         normal_in = normal_sum[CW] ? '1 : normal_sum[CW-1:0];
      end
      if (dropped) begin
         drop_in = drop_sum[CW] ? '1 : drop_sum[CW-1:0];
      end
      if (bad) begin
         bad_in = bad_sum[CW] ? '1 : bad_sum[CW-1:0];
      end
   end

   fsdd_hist u_hist (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .level     (in_data_ff.level),
      .bin_count (bin_count)
   );

   // Assemble the result.
   always_comb begin
      rsp_data_in.mismatch       = !match;
      rsp_data_in.missing_frames = missing;
      rsp_data_in.judged_bad     = bad;
      rsp_data_in.total_count    = total_in;
      rsp_data_in.normal_count   = normal_in;
      rsp_data_in.drop_count     = drop_in;
      rsp_data_in.bad_count      = bad_in;
      rsp_data_in.bin_count      = bin_count;
   end

   // Sequence state and counters advance with each checked frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= '0;
         seen_first_ff <= 1'b0;
         prev_start_ff <= '0;
         total_ff      <= '0;
         normal_ff     <= '0;
         drop_ff       <= '0;
         bad_ff        <= '0;
      end else if (advance) begin
         expected_ff   <= expected_in;
         seen_first_ff <= 1'b1;
         prev_start_ff <= in_data_ff.start_time;
         total_ff      <= total_in;
         normal_ff     <= normal_in;
         drop_ff       <= drop_in;
         bad_ff        <= bad_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   // A matched frame reports no missing frames and is never bad.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.mismatch |->
         (rsp_data_ff.missing_frames == '0) && !rsp_data_ff.judged_bad)
      else $error("matched frame reported missing frames or bad");

   // A mismatch always has at least one missing frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.mismatch |-> (rsp_data_ff.missing_frames != '0))
      else $error("mismatch with zero missing frames");

   // Once a frame has been checked, the total count is never zero.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (total_ff != '0) && seen_first_ff)
      else $error("checked frame not counted");

   // A held input frame is not lost while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input frame lost");

   // The first frame ever checked is always a match.
   assert property (@(posedge clock) disable iff (reset)
      advance && !seen_first_ff |=> rsp_valid_ff && !rsp_data_ff.mismatch)
      else $error("first frame reported as mismatch");
`endif

endmodule

`default_nettype wire

// ===== src/fsdd_hist.sv =====
// ============================================================================
// fsdd_hist: level histogram with saturating bins
// ----------------------------------------------------------------------------
// One bin per level below the bin count. Level zero and levels beyond the
// last bin are not counted. The updated count of the addressed bin is shown
// combinationally so that the caller can register it with the result.
// ============================================================================
`default_nettype none

module fsdd_hist (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               update,
   input  wire logic [fsdd_pkg::LEVEL_WIDTH-1:0]   level,
   output      fsdd_pkg::count_type                bin_count
);

   fsdd_pkg::count_type                       bins_ff [fsdd_pkg::LEVEL_BINS];
   logic                                      binned;
   logic [fsdd_pkg::BIN_INDEX_WIDTH-1:0]      bin_index;
   logic [fsdd_pkg::COUNT_WIDTH:0]            bin_sum;
   fsdd_pkg::count_type                       bin_in;

   // Decide whether the level has a bin and pick it.
   assign binned    = (level != '0) &&
                      ({1'b0, level} < (fsdd_pkg::LEVEL_WIDTH + 1)'(fsdd_pkg::LEVEL_BINS));
   assign bin_index = fsdd_pkg::BIN_INDEX_WIDTH'(level);

   // Saturating increment of the addressed bin.
   always_comb begin
      bin_sum = {1'b0, bins_ff[bin_index]} + (fsdd_pkg::COUNT_WIDTH + 1)'(1);
      bin_in  = bin_sum[fsdd_pkg::COUNT_WIDTH] ? '1 : bin_sum[fsdd_pkg::COUNT_WIDTH-1:0];
   end

   assign bin_count = binned ? bin_in : '0;

   // Bin storage, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fsdd_pkg::LEVEL_BINS; i++) begin
            bins_ff[i] <= '0;
         end
      end else if (update && binned) begin
         bins_ff[bin_index] <= bin_in;
      end
   end

endmodule

`default_nettype wire

// ===== sim/frame_sequence_drop_checker.sv =====
// ============================================================================
// frame_sequence_drop_checker: result checker for the frame sequence detector
// ----------------------------------------------------------------------------
// Watches the request, response and register channels of the detector. Each
// accepted frame is judged by a local copy of the sequence state, counters and
// level histogram, and the verdict is queued. Each accepted response is
// compared field by field with the oldest queued verdict.
// ============================================================================

module frame_sequence_drop_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  fsdd_pkg::req_payload_type            req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  fsdd_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [fsdd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fsdd_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                   error_count,
   output int                                   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   import fsdd_pkg::*;

   // Register copies.
   logic [LEVEL_WIDTH-1:0]       normal_level_cfg;
   logic [FRAME_WIDTH_WIDTH-1:0] frame_width_cfg;

   // Sequence state, counters and histogram.
   logic [TYPE_WIDTH-1:0] awaited_type;
   logic                  started;
   logic [TIME_WIDTH-1:0] last_start;
   count_type             level_bins [LEVEL_BINS];
   count_type             seen_total;
   count_type             seen_normal;
   count_type             seen_dropped;
   count_type             seen_bad;

   // Verdicts of accepted frames whose responses have not come yet.
   rsp_payload_type frame_verdicts [$];

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_WIDTH:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
   endfunction

   // Judges one frame against the sequence state and updates that state.
   function automatic rsp_payload_type judge_frame(input req_payload_type frame);
      rsp_payload_type            verdict;
      logic [TYPE_WIDTH-1:0]      phase;
      logic [TYPE_WIDTH-1:0]      gone;
      logic [THRESHOLD_WIDTH-1:0] drop_threshold;
      logic [TIME_WIDTH-1:0]      gap;
      logic [BIN_INDEX_WIDTH-1:0] bin_at;
      verdict = '0;
      phase   = TYPE_WIDTH'(frame.frame_type % PATTERN_LENGTH);
      bin_at  = BIN_INDEX_WIDTH'(frame.level);
      if (!started) begin
         awaited_type = phase;
         started      = 1'b1;
      end
      seen_total = sat_add(seen_total, 1);

      // Levels 1 to LEVEL_BINS-1 are binned; others report a zero bin count.
      if (frame.level != 0 && frame.level < LEVEL_BINS) begin
         level_bins[bin_at] = sat_add(level_bins[bin_at], 1);
         verdict.bin_count  = level_bins[bin_at];
      end

      if (phase == awaited_type) begin
         if (frame.level == normal_level_cfg) begin
            seen_normal = sat_add(seen_normal, 1);
         end
         awaited_type = TYPE_WIDTH'((awaited_type + 1) % PATTERN_LENGTH);
      end else begin
         // A long enough gap means frames went missing; a short one, a bad frame.
         gone = TYPE_WIDTH'((phase + PATTERN_LENGTH - awaited_type) % PATTERN_LENGTH);
         drop_threshold = THRESHOLD_WIDTH'(gone) * THRESHOLD_WIDTH'(frame_width_cfg);
         gap = (frame.start_time >= last_start) ? frame.start_time - last_start
                                                : last_start - frame.start_time;
         verdict.mismatch       = 1'b1;
         verdict.missing_frames = gone;
         if (gap >= TIME_WIDTH'(drop_threshold)) begin
            seen_dropped = sat_add(seen_dropped, COUNT_WIDTH'(gone));
         end else begin
            verdict.judged_bad = 1'b1;
            seen_bad           = sat_add(seen_bad, 1);
         end
         awaited_type = TYPE_WIDTH'((phase + 1) % PATTERN_LENGTH);
      end
      last_start = frame.start_time;

      verdict.total_count  = seen_total;
      verdict.normal_count = seen_normal;
      verdict.drop_count   = seen_dropped;
      verdict.bad_count    = seen_bad;
      return verdict;
   endfunction

   task automatic check_field(input string field, input count_type want,
                              input count_type got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_count++;
      end
   endtask

   // All channels are sampled at the rising edge, before the block's outputs move.
   always @(posedge clock) begin
      rsp_payload_type want;
      rsp_payload_type judged;
      if (reset) begin
         normal_level_cfg = NORMAL_LEVEL_RESET;
         frame_width_cfg  = FRAME_WIDTH_US_RESET;
         awaited_type     = '0;
         started          = 1'b0;
         last_start       = '0;
         seen_total       = '0;
         seen_normal      = '0;
         seen_dropped     = '0;
         seen_bad         = '0;
         for (int b = 0; b < LEVEL_BINS; b++) begin
            level_bins[b] = '0;
         end
         frame_verdicts.delete();
      end else begin
         // Register writes; unknown indexes leave everything unchanged.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NORMAL_LEVEL:   normal_level_cfg = csr_wdata[LEVEL_WIDTH-1:0];
               CSR_FRAME_WIDTH_US: frame_width_cfg  = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            judged         = judge_frame(req_payload);
            frame_verdicts = {frame_verdicts, judged};
         end

         if (rsp_valid && rsp_ready) begin
            if (frame_verdicts.size() == 0) begin
               $error("response transaction arrived with no frame awaiting it");
               error_count++;
            end else begin
               want = frame_verdicts.pop_front();
               check_field("mismatch", COUNT_WIDTH'(want.mismatch),
                           COUNT_WIDTH'(rsp_payload.mismatch));
               check_field("missing_frames", COUNT_WIDTH'(want.missing_frames),
                           COUNT_WIDTH'(rsp_payload.missing_frames));
               check_field("judged_bad", COUNT_WIDTH'(want.judged_bad),
                           COUNT_WIDTH'(rsp_payload.judged_bad));
               check_field("total_count", want.total_count, rsp_payload.total_count);
               check_field("normal_count", want.normal_count, rsp_payload.normal_count);
               check_field("drop_count", want.drop_count, rsp_payload.drop_count);
               check_field("bad_count", want.bad_count, rsp_payload.bad_count);
               check_field("bin_count", want.bin_count, rsp_payload.bin_count);
            end
         end
      end
      pending_results = frame_verdicts.size();
   end

endmodule

// ===== sim/frame_sequence_drop_detector_tb.sv =====
// ============================================================================
// frame_sequence_drop_detector_tb: top level of the detector's simulation
// ----------------------------------------------------------------------------
// Drives a directed frame sequence and then random phases of mostly
// well-formed pattern runs with skipped types, gaps near the drop threshold
// and noise, under several register settings and handshake profiles. A
// separate checker judges every frame and reports the failure count.
// ============================================================================

module frame_sequence_drop_detector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fsdd_pkg::*;

   localparam int PHASES             = 8;
   localparam int FRAMES_PER_PHASE   = 160;
   localparam int CYCLE_LIMIT        = 400000;
   localparam int FIRST_UNUSED_INDEX = int'(CSR_FRAME_WIDTH_US) + 1;
   localparam int LAST_INDEX         = (1 << CSR_INDEX_WIDTH) - 1;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         req_valid   = 1'b0;
   req_payload_type              req_payload = '0;
   logic                         rsp_ready   = 1'b0;
   logic                         csr_valid   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index   = '0;
   logic [CSR_DATA_WIDTH-1:0]    csr_wdata   = '0;
   logic                         req_ready;
   logic                         rsp_valid;
   rsp_payload_type              rsp_payload;
   logic                         csr_ready;
   int                           error_count;
   int                           pending_results;

   // Handshake profile: percent of cycles the sender idles and the receiver stalls.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int idle_profile  [4] = '{0, 83, 0, 14};
   int stall_profile [4] = '{0, 0, 83, 14};

   // Where the stream stands, used to shape the next frame.
   logic [TYPE_WIDTH-1:0]        next_type  = '0;
   logic [TIME_WIDTH-1:0]        last_time  = '0;
   logic [LEVEL_WIDTH-1:0]       normal_now = NORMAL_LEVEL_RESET;
   logic [FRAME_WIDTH_WIDTH-1:0] width_now  = FRAME_WIDTH_US_RESET;

   int frames_sent     = 0;
   int register_writes = 0;
   int cycle_count     = 0;

   frame_sequence_drop_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   frame_sequence_drop_checker sequence_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random according to the current profile.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Holds off the sender until every response has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results != 0) begin
         @(negedge clock);
      end
   endtask

   // Presents one frame and returns at the falling edge after its transaction.
   task automatic send_frame(input req_payload_type frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_payload = frame;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
      next_type = TYPE_WIDTH'((frame.frame_type + 1) % PATTERN_LENGTH);
      last_time = frame.start_time;
      @(negedge clock);
   endtask

   // Writes both registers, with a write to an unused index between them.
   task automatic write_config(input logic [LEVEL_WIDTH-1:0] normal,
                               input logic [FRAME_WIDTH_WIDTH-1:0] width);
      logic [CSR_INDEX_WIDTH-1:0] idx [3];
      logic [CSR_DATA_WIDTH-1:0]  val [3];
      idx[0] = CSR_NORMAL_LEVEL;
      val[0] = CSR_DATA_WIDTH'({$urandom(), normal});
      idx[1] = CSR_INDEX_WIDTH'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX));
      val[1] = CSR_DATA_WIDTH'($urandom());
      idx[2] = CSR_FRAME_WIDTH_US;
      val[2] = width;
      wait_drained();
      for (int w = 0; w < 3; w++) begin
         csr_valid = 1'b1;
         csr_index = idx[w];
         csr_wdata = val[w];
         do @(posedge clock); while (!csr_ready);
         register_writes++;
         @(negedge clock);
      end
      csr_valid  = 1'b0;
      normal_now = normal;
      width_now  = width;
   endtask

   // Mostly the next pattern type at the nominal spacing, some skips with gaps
   // close to the drop threshold in either direction, and some noise.
   function automatic req_payload_type make_frame();
      req_payload_type       frame;
      int unsigned           roll;
      int unsigned           skip;
      logic [TIME_WIDTH-1:0] threshold;
      logic [TIME_WIDTH-1:0] gap;
      roll = $urandom_range(99);
      case ($urandom_range(4))
         0, 1:    frame.level = normal_now;
         2, 3:    frame.level = LEVEL_WIDTH'($urandom_range(LEVEL_BINS + 1));
         default: frame.level = LEVEL_WIDTH'($urandom());
      endcase
      if (roll < 65) begin
         frame.frame_type = next_type;
         frame.start_time = last_time + width_now + $urandom_range(20) - 10;
      end else if (roll < 85) begin
         skip             = $urandom_range(1, PATTERN_LENGTH - 1);
         frame.frame_type = TYPE_WIDTH'((next_type + skip) % PATTERN_LENGTH);
         threshold        = skip * width_now;
         case ($urandom_range(3))
            0:       gap = threshold - 1;
            1:       gap = threshold;
            2:       gap = threshold + 1;
            default: gap = $urandom_range(threshold + 2);
         endcase
         frame.start_time = ($urandom_range(3) == 0) ? last_time - gap : last_time + gap;
      end else begin
         frame.frame_type = TYPE_WIDTH'($urandom());
         frame.start_time = $urandom();
      end
      return frame;
   endfunction

   initial begin
      int unsigned width_plan [5] = '{0, 20'hFFFFF, 1000000, 1, 16667};
      int unsigned level_plan [3] = '{0, 255, 1};
      int          pause_at;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: first frame near the top of time, exact and short gaps,
      // backward time, every missing count, unbinned and extreme levels.
      write_config(8'd3, 20'd1000);
      send_frame('{2'd2, 32'hFFFF_FFF0, 8'd3});
      send_frame('{2'd3, 32'd5, 8'd0});
      send_frame('{2'd0, 32'd1005, 8'd15});
      send_frame('{2'd1, 32'd2005, 8'd16});
      send_frame('{2'd3, 32'd3005, 8'd255});
      send_frame('{2'd2, 32'd5004, 8'd3});
      send_frame('{2'd1, 32'd7004, 8'd8});
      send_frame('{2'd1, 32'd4004, 8'd1});
      send_frame('{2'd2, 32'd5004, 8'd3});
      send_frame('{2'd0, 32'd4005, 8'd7});
      send_frame('{2'd1, 32'd0, 8'd3});
      send_frame('{2'd3, 32'hFFFF_FFFF, 8'd128});
      send_frame('{2'd1, 32'hFFFF_FFFF, 8'd2});
      send_frame('{2'd2, 32'h8000_0000, 8'd254});
      send_frame('{2'd3, 32'h7FFF_FFFF, 8'd4});
      send_frame('{2'd0, 32'h5555_5555, 8'd3});
      send_frame('{2'd2, 32'hAAAA_AAAA, 8'd9});

      // A zero frame width turns every mismatch into drops; level zero is normal.
      write_config(8'd0, 20'd0);
      send_frame('{2'd0, 32'hAAAA_AAAA, 8'd0});
      send_frame('{2'd1, 32'hAAAA_AAAB, 8'd0});

      // The widest frame width pushes the threshold past two million.
      write_config(8'd255, 20'hFFFFF);
      send_frame('{2'd0, 32'hAAAA_AAAB, 8'd255});
      send_frame('{2'd1, 32'hAACA_AAA9, 8'd255});
      send_frame('{2'd0, 32'hAAEA_AAA8, 8'd15});
      send_frame('{2'd3, 32'hAADA_AAA8, 8'd14});

      // Random phases, each with its own settings and handshake profile.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_config((ph < 3) ? LEVEL_WIDTH'(level_plan[ph]) : LEVEL_WIDTH'($urandom()),
                      (ph < 5) ? FRAME_WIDTH_WIDTH'(width_plan[ph])
                               : FRAME_WIDTH_WIDTH'($urandom()));
         send_idle_pct = idle_profile[ph % 4];
         stall_pct     = stall_profile[ph % 4];
         pause_at      = $urandom_range(20, FRAMES_PER_PHASE - 20);
         for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
            if (k == pause_at) begin
               wait_drained();
            end
            send_frame(make_frame());
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d frames, a directed sequence and %0d random phases, with %0d register writes.",
               frames_sent, PHASES, register_writes);
      $display("Phases ran free-flowing, with sender idling, receiver stalls, and both.");
      if (error_count == 0 && pending_results == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/fsdd_pkg.sv
src/fsdd_hist.sv
src/frame_sequence_drop_detector.sv
sim/frame_sequence_drop_checker.sv
sim/frame_sequence_drop_detector_tb.sv
